// File: hdl/mftach_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the multi-fan tachometer
package mftach_pkg;

	// fan channel count default
	localparam int FANS_DEFAULT = 4;

	// field widths
	localparam int OP_W    = 2;
	localparam int FAN_W   = 4;
	localparam int RPM_W   = 32;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int WIN_W   = 16;
	localparam int MULT_W  = 4;

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] CFG_IDX_WINDOW = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_IDX_MULT   = 1'd1;
	localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd1000;
	localparam logic [MULT_W-1:0] MULT_RESET     = 4'd4;

	// item opcodes
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// rpm arithmetic
	localparam logic [COUNT_W-1:0] RPM_SCALE = 16'd60000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [RPM_W-1:0]   RPM_MAX   = 32'hFFFF_FFFF;
	localparam int NUM_W     = 36;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// per-fan state entry
	typedef struct packed {
		logic [TIME_W-1:0]  win_start;
		logic [COUNT_W-1:0] pulse_cnt;
		logic [COUNT_W-1:0] latch_cnt;
		logic [TIME_W-1:0]  latch_dur;
	} fan_ent_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: hdl/mftach_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for items and results
interface mftach_in_if;
	import mftach_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [FAN_W-1:0] fan_index;

	modport source (output valid, output opcode, output fan_index, input ready);
	modport sink (input valid, input opcode, input fan_index, output ready);
endinterface

interface mftach_out_if;
	import mftach_pkg::*;
	logic             valid;
	logic             ready;
	logic [RPM_W-1:0] rpm;
	logic [FAN_W-1:0] fan_echo;

	modport source (output valid, output rpm, output fan_echo, input ready);
	modport sink (input valid, input rpm, input fan_echo, output ready);
endinterface

// File: hdl/mftach_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module mftach_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mftach_pkg::div_req_t  req,
	output mftach_pkg::div_rsp_t  rsp
);
	import mftach_pkg::*;

	logic [NUM_W-1:0]  dvd_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W:0]   rem_sh;
	logic [TIME_W+1:0] diff;
	logic              ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, dvd_q[NUM_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
		ge     = ~diff[TIME_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath, quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// File: hdl/multi_fan_tachometer_rpm_top.sv
`timescale 1ns / 1ps
// multi-fan tachometer: per-fan pulse windows in a state memory, rpm by division
// per item: tick advances time; edge does memory read and update; out-of-range read goes
// to the result register; valid-fan read does memory read, update, and at zero duration
// result register, else two multiply steps, divider launch, 36 divider steps, done, result
// register, and waits on a held result; one item at a time, the 36-step divider sets read rate
// reset: arst_n clears time, configuration to 1000 ms and x4, and all fan entries by valid bits
module multi_fan_tachometer_rpm_top #(
	parameter int FANS = mftach_pkg::FANS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mftach_in_if.sink                         in_chan,
	mftach_out_if.source                      out_chan,
	input  logic                              cfg_we,
	input  logic [mftach_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [mftach_pkg::CFG_DW-1:0]     cfg_data
);
	import mftach_pkg::*;

	localparam int FAN_AW = (FANS > 1) ? $clog2(FANS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MOD,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [OP_W-1:0]    op_q;
	logic [FAN_W-1:0]   fan_q;
	logic [TIME_W-1:0]  now_q;
	logic [WIN_W-1:0]   window_q;
	logic [MULT_W-1:0]  mult_q;
	logic [COUNT_W-1:0] lc_q;
	logic [TIME_W-1:0]  ld_q;
	logic [TIME_W-1:0]  prod1_q;
	logic [NUM_W-1:0]   num_q;
	logic [RPM_W-1:0]   res_q;
	logic               out_v_q;
	logic [RPM_W-1:0]   out_rpm_q;
	logic [FAN_W-1:0]   out_fan_q;

	fan_ent_t           mem [FANS];
	logic [FANS-1:0]    vld_q;
	fan_ent_t           rd_q;
	logic               rd_vld_q;
	fan_ent_t           cur;
	fan_ent_t           upd;
	logic [COUNT_W-1:0] pc_inc;
	logic [TIME_W-1:0]  close_at;
	logic               mem_we;
	logic [FAN_AW-1:0]  addr;
	logic               in_fire;
	logic               in_fan_ok;
	logic               slot_free;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign addr      = fan_q[FAN_AW-1:0];
	assign in_fire   = in_chan.valid && in_chan.ready;
	assign in_fan_ok = {1'b0, in_chan.fan_index} < (FAN_W+1)'(FANS);
	assign slot_free = !out_v_q || out_chan.ready;
	assign mem_we    = (state_q == ST_MOD);

	assign in_chan.ready     = (state_q == ST_IDLE);
	assign out_chan.valid    = out_v_q;
	assign out_chan.rpm      = out_rpm_q;
	assign out_chan.fan_echo = out_fan_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			mult_q   <= MULT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_WINDOW: window_q <= cfg_data[WIN_W-1:0];
				CFG_IDX_MULT:   mult_q   <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	// entry update: count the edge, then close the window if due
	always_comb begin
		cur      = rd_vld_q ? rd_q : '0;
		pc_inc   = cur.pulse_cnt;
		if (op_q == OP_EDGE && cur.pulse_cnt != COUNT_MAX) begin
			pc_inc = cur.pulse_cnt + 1'b1;
		end
		upd           = cur;
		upd.pulse_cnt = pc_inc;
		close_at      = cur.win_start + TIME_W'(window_q);
		if (close_at < now_q) begin
			upd.latch_cnt = pc_inc;
			upd.latch_dur = now_q - cur.win_start;
			upd.win_start = now_q;
			upd.pulse_cnt = '0;
		end
	end

	// state memory, synchronous read and write-back
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rd_q <= mem[addr];
		end
		if (mem_we) begin
			mem[addr] <= upd;
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_RD) begin
				rd_vld_q <= vld_q[addr];
			end
			if (mem_we) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	// divider launch once the numerator register holds the product
	always_comb begin
		div_req.start    = (state_q == ST_DIV) && !div_rsp.busy && !div_rsp.done;
		div_req.dividend = num_q;
		div_req.divisor  = ld_q;
	end

	mftach_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_TICK;
			fan_q     <= '0;
			now_q     <= '0;
			lc_q      <= '0;
			ld_q      <= '0;
			prod1_q   <= '0;
			num_q     <= '0;
			res_q     <= '0;
			out_v_q   <= 1'b0;
			out_rpm_q <= '0;
			out_fan_q <= '0;
		end else begin
			if (out_chan.valid && out_chan.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q  <= in_chan.opcode;
						fan_q <= in_chan.fan_index;
						res_q <= '0;
						case (in_chan.opcode)
							OP_TICK: now_q <= now_q + 1'b1;
							OP_EDGE: begin
								if (in_fan_ok) begin
									state_q <= ST_RD;
								end
							end
							OP_READ: state_q <= in_fan_ok ? ST_RD : ST_OUT;
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_MOD;
				ST_MOD: begin
					lc_q <= upd.latch_cnt;
					ld_q <= upd.latch_dur;
					if (op_q != OP_READ) begin
						state_q <= ST_IDLE;
					end else if (upd.latch_dur == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					prod1_q <= TIME_W'(RPM_SCALE) * TIME_W'(lc_q);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					num_q   <= NUM_W'(prod1_q) * NUM_W'(mult_q);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient[NUM_W-1:RPM_W] != '0) begin
							res_q <= RPM_MAX;
						end else begin
							res_q <= div_rsp.quotient[RPM_W-1:0];
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						out_v_q   <= 1'b1;
						out_rpm_q <= res_q;
						out_fan_q <= fan_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider is never restarted while it runs
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a memory read is always followed by its write-back
	a_rd_then_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_MOD))
		else $error("memory read not followed by update");

	// only in-range fans touch the state memory
	a_we_fan_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, fan_q} < (FAN_W+1)'(FANS)))
		else $error("state memory write for out-of-range fan");

	// divider completes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider result outside divide state");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the multi-fan tachometer with its own rpm predictor
module testbench;
	import mftach_pkg::*;

	localparam int FANS = FANS_DEFAULT;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 60;
	localparam int BURST_EDGES = 60;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic [FAN_W-1:0] fan;
	} rpm_res_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [OP_W-1:0]    op;
		logic [FAN_W-1:0]   fan;
		logic [CFG_IW-1:0]  reg_idx;
		logic [CFG_DW-1:0]  value;
		bit                 typed;
		logic [RPM_W-1:0]   rpm;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	mftach_in_if  in_chan();
	mftach_out_if out_chan();

	multi_fan_tachometer_rpm_top #(
		.FANS(FANS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_chan(in_chan),
		.out_chan(out_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the tachometer state and registers
	logic [TIME_W-1:0]  fan_now;
	logic [TIME_W-1:0]  fan_start[FANS];
	logic [COUNT_W-1:0] fan_pulses[FANS];
	logic [COUNT_W-1:0] fan_held_count[FANS];
	logic [TIME_W-1:0]  fan_held_dur[FANS];
	logic [WIN_W-1:0]   window_len;
	logic [MULT_W-1:0]  pulse_mult;

	rpm_res_t  rpm_expect_q[$];
	stim_row_t plan_q[$];

	int src_idle_pct;
	int snk_idle_pct;
	int n_errors;
	int n_items;
	int n_checked;
	int n_saturated;
	int n_settings;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// close the fan's window once its length has run out
	function automatic void refresh_window(input int f);
		logic [TIME_W-1:0] close_at;
		close_at = fan_start[f] + TIME_W'(window_len);
		if (close_at < fan_now) begin
			fan_held_count[f] = fan_pulses[f];
			fan_held_dur[f] = fan_now - fan_start[f];
			fan_start[f] = fan_now;
			fan_pulses[f] = '0;
		end
	endfunction

	// advance the predicted state by one transaction; returns 1 when a result is due
	function automatic bit predict_rpm(input logic [OP_W-1:0] op, input logic [FAN_W-1:0] fan,
			output rpm_res_t res);
		logic [63:0] num;
		logic [63:0] quot;
		bit in_range;
		in_range = (int'(fan) < FANS);
		res = '0;
		res.fan = fan;
		case (op)
			OP_TICK: begin
				fan_now = fan_now + 1'b1;
				return 1'b0;
			end
			OP_EDGE: begin
				if (in_range) begin
					if (fan_pulses[fan] != COUNT_MAX)
						fan_pulses[fan] = fan_pulses[fan] + 1'b1;
					refresh_window(int'(fan));
				end
				return 1'b0;
			end
			OP_READ: begin
				if (in_range) begin
					refresh_window(int'(fan));
					if (fan_held_dur[fan] != '0) begin
						num = 64'(RPM_SCALE) * 64'(fan_held_count[fan]) * 64'(pulse_mult);
						quot = num / 64'(fan_held_dur[fan]);
						res.rpm = (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// offer one transaction, with random gaps, and predict it once accepted
	task automatic send_item(input logic [OP_W-1:0] op, input logic [FAN_W-1:0] fan,
			input bit typed, input logic [RPM_W-1:0] typed_rpm);
		rpm_res_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			in_chan.valid <= 1'b0;
			@(posedge clk);
		end
		in_chan.valid <= 1'b1;
		in_chan.opcode <= op;
		in_chan.fan_index <= fan;
		@(posedge clk);
		while (!in_chan.ready)
			@(posedge clk);
		n_items++;
		if (predict_rpm(op, fan, res)) begin
			if (typed)
				res.rpm = typed_rpm;
			rpm_expect_q.push_back(res);
		end
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain_results();
		in_chan.valid <= 1'b0;
		while (rpm_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_WINDOW)
			window_len = val[WIN_W-1:0];
		else
			pulse_mult = val[MULT_W-1:0];
		n_settings++;
	endtask

	task automatic add_row(input row_kind_t kind, input logic [OP_W-1:0] op,
			input logic [FAN_W-1:0] fan, input logic [CFG_IW-1:0] idx,
			input logic [CFG_DW-1:0] val, input bit typed, input logic [RPM_W-1:0] rpm);
		stim_row_t row;
		row.kind = kind;
		row.op = op;
		row.fan = fan;
		row.reg_idx = idx;
		row.value = val;
		row.typed = typed;
		row.rpm = rpm;
		plan_q.push_back(row);
	endtask

	// random transactions under one register setting
	task automatic run_phase(input logic [CFG_DW-1:0] win, input logic [CFG_DW-1:0] mult,
			input int s_idle, input int r_idle, input int count, input int tick_pct);
		int roll;
		logic [OP_W-1:0] op;
		logic [FAN_W-1:0] fan;
		write_reg(CFG_IDX_WINDOW, win);
		write_reg(CFG_IDX_MULT, mult);
		src_idle_pct = s_idle;
		snk_idle_pct = r_idle;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < tick_pct)
				op = OP_TICK;
			else if (roll < tick_pct + 35)
				op = OP_EDGE;
			else if (roll < 95)
				op = OP_READ;
			else
				op = OP_UNUSED;
			if ($urandom_range(99) < 85)
				fan = FAN_W'($urandom_range(FANS - 1));
			else
				fan = FAN_W'($urandom_range(15));
			send_item(op, fan, 1'b0, '0);
		end
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin : check_results
		rpm_res_t oldest;
		if (arst_n && out_chan.valid && out_chan.ready) begin
			if (rpm_expect_q.size() == 0) begin
				$error("unexpected result: rpm %0d fan_echo %0d", out_chan.rpm, out_chan.fan_echo);
				n_errors++;
			end else begin
				oldest = rpm_expect_q.pop_front();
				n_checked++;
				if (out_chan.rpm == RPM_MAX)
					n_saturated++;
				if (out_chan.rpm !== oldest.rpm) begin
					$error("rpm mismatch: expected %0d, actual %0d", oldest.rpm, out_chan.rpm);
					n_errors++;
				end
				if (out_chan.fan_echo !== oldest.fan) begin
					$error("fan_echo mismatch: expected %0d, actual %0d",
						oldest.fan, out_chan.fan_echo);
					n_errors++;
				end
			end
		end
		out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// run limit
	initial begin
		#(64'd50_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		in_chan.valid = 1'b0;
		in_chan.opcode = OP_TICK;
		in_chan.fan_index = '0;
		out_chan.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errors = 0;
		n_items = 0;
		n_checked = 0;
		n_saturated = 0;
		n_settings = 0;
		src_idle_pct = 28;
		snk_idle_pct = 62;
		fan_now = '0;
		window_len = WINDOW_RESET;
		pulse_mult = MULT_RESET;
		for (int f = 0; f < FANS; f++) begin
			fan_start[f] = '0;
			fan_pulses[f] = '0;
			fan_held_count[f] = '0;
			fan_held_dur[f] = '0;
		end

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset state, bad fans, unused opcode, register extremes
		add_row(ROW_ITEM, OP_READ, 4'd0, '0, '0, 1'b1, '0);
		add_row(ROW_ITEM, OP_READ, 4'd3, '0, '0, 1'b1, '0);
		add_row(ROW_ITEM, OP_READ, 4'd15, '0, '0, 1'b1, '0);
		add_row(ROW_ITEM, OP_READ, 4'd4, '0, '0, 1'b1, '0);
		add_row(ROW_ITEM, OP_UNUSED, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_UNUSED, 4'd15, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd15, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd3, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_TICK, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd0, '0, '0, 1'b1, '0);
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_WINDOW, 16'd1, 1'b0, '0);
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_MULT, 16'd15, 1'b0, '0);
		add_row(ROW_ITEM, OP_TICK, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd3, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd3, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd1, '0, '0, 1'b0, '0);
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_WINDOW, 16'hFFFF, 1'b0, '0);
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_MULT, 16'd1, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd2, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_TICK, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd2, '0, '0, 1'b0, '0);
		// zero window and zero multiplier
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_WINDOW, 16'd0, 1'b0, '0);
		add_row(ROW_WRITE, OP_TICK, '0, CFG_IDX_MULT, 16'd0, 1'b0, '0);
		add_row(ROW_ITEM, OP_TICK, 4'd0, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_EDGE, 4'd1, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, OP_READ, 4'd1, '0, '0, 1'b1, '0);
		add_row(ROW_ITEM, OP_READ, 4'd0, '0, '0, 1'b1, '0);
		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_WRITE)
				write_reg(plan_q[i].reg_idx, plan_q[i].value);
			else
				send_item(plan_q[i].op, plan_q[i].fan, plan_q[i].typed, plan_q[i].rpm);
		end

		// random traffic, sender idling less than receiver, then the reverse
		run_phase(16'd3, 16'd4, 28, 62, 300, 40);
		run_phase(16'd20, 16'd9, 62, 28, 300, 40);

		// edge burst on one fan, then a zero-length window closes it
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(CFG_IDX_WINDOW, 16'd0);
		send_item(OP_EDGE, 4'd0, 1'b0, '0);
		write_reg(CFG_IDX_WINDOW, 16'hFFFF);
		write_reg(CFG_IDX_MULT, 16'd15);
		for (int i = 0; i < BURST_EDGES; i++)
			send_item(OP_EDGE, 4'd0, 1'b0, '0);
		write_reg(CFG_IDX_WINDOW, 16'd0);
		send_item(OP_TICK, 4'd0, 1'b0, '0);
		send_item(OP_READ, 4'd0, 1'b0, '0);

		// random traffic with no idling
		run_phase(16'd1, 16'd15, 0, 0, 200, 30);
		run_phase(16'hFFFF, 16'd1, 0, 0, 120, 40);
		run_phase(16'd0, 16'd2, 0, 0, 150, 30);

		drain_results();
		$display("covered %0d transactions (%0d-edge burst on one fan) over %0d register writes",
			n_items, BURST_EDGES, n_settings);
		$display("checked %0d rpm results, %0d of them saturated", n_checked, n_saturated);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
